/* sv/mpe_pkg.sv */
// Shared constants, types and register codes of the M_PDU packet extractor.
`timescale 1ns / 1ps
package mpe_pkg;

    localparam int ZONE_BYTES  = 884;
    localparam int CHANNELS    = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int CHAN_W    = 6;
    localparam int CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_MAX   = ZONE_BYTES + 2;
    localparam int POS_W     = $clog2(POS_MAX + 1);
    localparam int PTR_W     = 11;
    localparam int CMP_W     = (POS_W > PTR_W) ? POS_W : PTR_W;
    localparam int QUEUE_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_W     = 16;
    localparam int REM_W     = 17;
    localparam int HDR_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [PTR_W-1:0] NO_HEADER_PTR = 11'h7FF;
    localparam logic [2:0]       HDR_BYTES     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_FILLER_CHANNEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH       = 2'd2;

    localparam logic [CHAN_W-1:0] RST_FILLER_CHANNEL   = 6'd63;
    localparam logic [1:0]        RST_EXPECTED_VERSION = 2'd1;
    localparam logic [LEN_W-1:0]  RST_MIN_LENGTH       = 16'd5;

    localparam logic CMD_CLEAR_SYNC = 1'b0;
    localparam logic CMD_ZONE       = 1'b1;

    typedef struct packed {
        logic              op;
        logic              hdr_start;
        logic [CHAN_W-1:0] chan;
        logic [7:0]        data;
    } t_cmd;

    typedef struct packed {
        logic [2:0]       count;
        logic [HDR_W-1:0] hdr;
        logic [REM_W-1:0] rem;
    } t_chan_state;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic [CHAN_W-1:0] out_channel;
        logic [10:0]       app_id;
        logic [2:0]        packet_version;
        logic              packet_type;
        logic              has_secondary;
        logic [1:0]        seq_flags;
        logic [13:0]       seq_number;
        logic              last_byte;
    } t_result;

endpackage

/* sv/mpe_ifs.sv */
// Handshake channel interfaces for input bytes, packet bytes and register writes.
`timescale 1ns / 1ps
interface mpe_in_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [5:0] channel;
    logic [1:0] frame_version;
    logic [7:0] in_byte;

    modport source(output valid, frame_start, channel, frame_version, in_byte, input ready);
    modport sink(input valid, frame_start, channel, frame_version, in_byte, output ready);
endinterface

interface mpe_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [5:0]  out_channel;
    logic [10:0] app_id;
    logic [2:0]  packet_version;
    logic        packet_type;
    logic        has_secondary;
    logic [1:0]  seq_flags;
    logic [13:0] seq_number;
    logic        last_byte;

    modport source(output valid, out_byte, out_channel, app_id, packet_version, packet_type,
                   has_secondary, seq_flags, seq_number, last_byte, input ready);
    modport sink(input valid, out_byte, out_channel, app_id, packet_version, packet_type,
                 has_secondary, seq_flags, seq_number, last_byte, output ready);
endinterface

interface mpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* sv/mpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mpe_front.sv */
// Front end: tracks frame position and pointer, turns each kept zone byte or bad pointer into a command.
`timescale 1ns / 1ps
module mpe_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mpe_in_if.sink                   i_in,
    input  logic [5:0]               i_filler_channel,
    input  logic [1:0]               i_expected_version,
    input  logic                     i_full,
    output logic                     o_push,
    output mpe_pkg::t_cmd            o_cmd
);

    logic                            r_discard;
    logic                            n_discard;
    logic [mpe_pkg::POS_W-1:0]       r_pos;
    logic [mpe_pkg::POS_W-1:0]       n_pos;
    logic [mpe_pkg::PTR_W-1:0]       r_ptr;
    logic [mpe_pkg::PTR_W-1:0]       n_ptr;
    logic [mpe_pkg::POS_W-1:0]       pos;
    logic [mpe_pkg::POS_W-1:0]       zone_idx;
    logic                            accept;
    logic                            chan_ok;
    logic                            ptr_ok;
    logic                            cmd_valid;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        pos       = i_in.frame_start ? '0 : r_pos;
        n_discard = r_discard;
        if (i_in.frame_start) begin
            n_discard = (i_in.channel == i_filler_channel) ||
                        (i_in.frame_version != i_expected_version);
        end
        n_pos = (pos < mpe_pkg::POS_W'(mpe_pkg::POS_MAX)) ? pos + 1'b1 : pos;
        chan_ok  = {1'b0, i_in.channel} < (mpe_pkg::CHAN_W + 1)'(mpe_pkg::CHANNELS);
        zone_idx = pos - mpe_pkg::POS_W'(2);
        ptr_ok   = mpe_pkg::CMP_W'(r_ptr) < mpe_pkg::CMP_W'(mpe_pkg::ZONE_BYTES);
        n_ptr    = r_ptr;
        cmd_valid       = 1'b0;
        o_cmd.op        = mpe_pkg::CMD_ZONE;
        o_cmd.hdr_start = 1'b0;
        o_cmd.chan      = i_in.channel;
        o_cmd.data      = i_in.in_byte;
        if (!n_discard && chan_ok) begin
            if (pos == '0) begin
                n_ptr = {i_in.in_byte[2:0], 8'h00};
            end else if (pos == mpe_pkg::POS_W'(1)) begin
                n_ptr = {r_ptr[10:8], i_in.in_byte};
                if ((mpe_pkg::CMP_W'(n_ptr) >= mpe_pkg::CMP_W'(mpe_pkg::ZONE_BYTES)) &&
                    (n_ptr != mpe_pkg::NO_HEADER_PTR)) begin
                    cmd_valid = 1'b1;
                    o_cmd.op  = mpe_pkg::CMD_CLEAR_SYNC;
                end
            end else if (pos < mpe_pkg::POS_W'(mpe_pkg::POS_MAX)) begin
                cmd_valid       = 1'b1;
                o_cmd.hdr_start = ptr_ok &&
                                  (mpe_pkg::CMP_W'(zone_idx) == mpe_pkg::CMP_W'(r_ptr));
            end
        end
    end

    assign o_push = accept && cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard <= 1'b1;
            r_pos     <= '0;
            r_ptr     <= '0;
        end else if (accept) begin
            r_discard <= n_discard;
            r_pos     <= n_pos;
            r_ptr     <= n_ptr;
        end
    end

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mpe_pkg::POS_W'(mpe_pkg::POS_MAX))
        else $error("Zone position ran past its saturation value.");

    a_start_ptr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.hdr_start |->
            mpe_pkg::CMP_W'(r_ptr) < mpe_pkg::CMP_W'(mpe_pkg::ZONE_BYTES))
        else $error("Header start issued under an out-of-zone pointer.");
`endif

endmodule

/* sv/mpe_cmd_queue.sv */
// Short command queue between the byte classifier and the per-channel engine.
`timescale 1ns / 1ps
module mpe_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpe_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mpe_pkg::t_cmd o_cmd
);

    mpe_pkg::t_cmd                  r_mem [mpe_pkg::QUEUE_DEPTH];
    logic [mpe_pkg::QUEUE_AW-1:0]   r_wr;
    logic [mpe_pkg::QUEUE_AW-1:0]   r_rd;
    logic [mpe_pkg::QUEUE_AW:0]     r_count;
    logic                           push_en;
    logic                           pop_en;

    assign o_full  = r_count == (mpe_pkg::QUEUE_AW + 1)'(mpe_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_wr <= (r_wr == mpe_pkg::QUEUE_AW'(mpe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_en) begin
                r_rd <= (r_rd == mpe_pkg::QUEUE_AW'(mpe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (!push_en && pop_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en && !pop_en |=> r_count == $past(r_count) + 1'b1)
        else $error("Queue fill count did not follow a lone push.");
`endif

endmodule

/* sv/mpe_back.sv */
// Back end: per-channel sync, header collection and length tracking, with result register.
`timescale 1ns / 1ps
module mpe_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  mpe_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    input  logic [mpe_pkg::LEN_W-1:0] i_min_length,
    mpe_out_if.source                 o_out
);

    localparam int SW = $bits(mpe_pkg::t_chan_state);

    logic                          r_b_valid;
    mpe_pkg::t_cmd                 r_b_cmd;
    logic                          r_fwd_valid;
    logic [mpe_pkg::CHAN_W-1:0]    r_fwd_chan;
    mpe_pkg::t_chan_state          r_fwd_state;
    logic [mpe_pkg::CHANNELS-1:0]  r_sync;
    logic                          r_out_valid;
    mpe_pkg::t_result              r_out;

    logic [SW-1:0]                 rdata;
    mpe_pkg::t_chan_state          cur;
    mpe_pkg::t_chan_state          base;
    mpe_pkg::t_chan_state          nxt;
    mpe_pkg::t_result              res;
    logic [mpe_pkg::CHAN_AW-1:0]   idx;
    logic [mpe_pkg::HDR_W-1:0]     hdr_new;
    logic [mpe_pkg::REM_W-1:0]     rem_dec;
    logic                          synced;
    logic                          sync_n;
    logic                          b_we;
    logic                          emit;
    logic                          out_free;
    logic                          b_adv;
    logic                          b_fire;

    assign out_free = !r_out_valid || o_out.ready;
    assign b_adv    = !r_b_valid || out_free;
    assign b_fire   = r_b_valid && out_free;
    assign o_pop    = i_q_valid && b_adv;
    assign idx      = r_b_cmd.chan[mpe_pkg::CHAN_AW-1:0];

    mpe_ram #(
        .WIDTH(SW),
        .DEPTH(mpe_pkg::CHANNELS)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (b_fire && b_we),
        .i_waddr(idx),
        .i_wdata(nxt),
        .i_re   (o_pop),
        .i_raddr(i_cmd.chan[mpe_pkg::CHAN_AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        cur     = (r_fwd_valid && (r_fwd_chan == r_b_cmd.chan)) ? r_fwd_state : rdata;
        synced  = r_sync[idx];
        sync_n  = synced;
        b_we    = 1'b0;
        emit    = 1'b0;
        base    = r_b_cmd.hdr_start ? '0 : cur;
        nxt     = base;
        hdr_new = {base.hdr[mpe_pkg::HDR_W-9:0], r_b_cmd.data};
        rem_dec = (base.rem != '0) ? base.rem - 1'b1 : '0;
        res.out_byte       = r_b_cmd.data;
        res.out_channel    = r_b_cmd.chan;
        res.app_id         = base.hdr[42:32];
        res.packet_version = base.hdr[47:45];
        res.packet_type    = base.hdr[44];
        res.has_secondary  = base.hdr[43];
        res.seq_flags      = base.hdr[31:30];
        res.seq_number     = base.hdr[29:16];
        res.last_byte      = rem_dec == '0;
        if (r_b_cmd.op == mpe_pkg::CMD_CLEAR_SYNC) begin
            sync_n = 1'b0;
        end else if (synced || r_b_cmd.hdr_start) begin
            sync_n = 1'b1;
            b_we   = 1'b1;
            if (base.count < mpe_pkg::HDR_BYTES) begin
                nxt.hdr   = hdr_new;
                nxt.count = base.count + 1'b1;
                if (nxt.count == mpe_pkg::HDR_BYTES) begin
                    if (hdr_new[mpe_pkg::LEN_W-1:0] < i_min_length) begin
                        sync_n = 1'b0;
                    end else begin
                        nxt.rem = {1'b0, hdr_new[mpe_pkg::LEN_W-1:0]} + 1'b1;
                    end
                end
            end else begin
                emit    = 1'b1;
                nxt.rem = rem_dec;
                if (res.last_byte) begin
                    nxt.count = '0;
                    nxt.hdr   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_sync      <= '0;
        end else begin
            if (b_adv) begin
                r_b_valid   <= o_pop;
                r_fwd_valid <= o_pop && b_fire && b_we;
            end
            if (out_free) begin
                r_out_valid <= b_fire && emit;
            end
            if (b_fire) begin
                r_sync[idx] <= sync_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_cmd <= i_cmd;
        end
        if (b_adv) begin
            r_fwd_chan  <= r_b_cmd.chan;
            r_fwd_state <= nxt;
        end
        if (b_fire && emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.out_channel    = r_out.out_channel;
    assign o_out.app_id         = r_out.app_id;
    assign o_out.packet_version = r_out.packet_version;
    assign o_out.packet_type    = r_out.packet_type;
    assign o_out.has_secondary  = r_out.has_secondary;
    assign o_out.seq_flags      = r_out.seq_flags;
    assign o_out.seq_number     = r_out.seq_number;
    assign o_out.last_byte      = r_out.last_byte;

`ifndef SYNTH
    a_fwd_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_b_valid)
        else $error("State bypass armed without a command in the engine stage.");

    a_emit_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && emit |-> r_b_cmd.op == mpe_pkg::CMD_ZONE)
        else $error("Packet beat produced by a sync-clear command.");
`endif

endmodule

/* sv/mpdu_packet_extractor.sv */
// Top level: M_PDU space packet extractor with register port, classifier, queue and engine.
// A byte that yields a packet beat passes the command queue, engine command register and result register.
// Throughput: one input beat per cycle, sustained, while the output channel keeps up.
// The state RAM is read once and written at most once per command; a bypass covers back-to-back commands.
// Reset (synchronous, active low) clears the sync flags, frame tracking, queue and registers.
// The per-channel state RAM is not cleared; each entry is written before it is used.
`timescale 1ns / 1ps
module mpdu_packet_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpe_in_if.sink     i_in,
    mpe_out_if.source  o_out,
    mpe_cfg_if.sink    i_cfg
);

    logic [mpe_pkg::CHAN_W-1:0] r_filler_channel;
    logic [1:0]                 r_expected_version;
    logic [mpe_pkg::LEN_W-1:0]  r_min_length;
    logic                       q_full;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_valid;
    mpe_pkg::t_cmd              front_cmd;
    mpe_pkg::t_cmd              q_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filler_channel   <= mpe_pkg::RST_FILLER_CHANNEL;
            r_expected_version <= mpe_pkg::RST_EXPECTED_VERSION;
            r_min_length       <= mpe_pkg::RST_MIN_LENGTH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mpe_pkg::CFG_FILLER_CHANNEL: begin
                    r_filler_channel <= i_cfg.data[mpe_pkg::CHAN_W-1:0];
                end
                mpe_pkg::CFG_EXPECTED_VERSION: begin
                    r_expected_version <= i_cfg.data[1:0];
                end
                mpe_pkg::CFG_MIN_LENGTH: begin
                    r_min_length <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    mpe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (i_in),
        .i_filler_channel  (r_filler_channel),
        .i_expected_version(r_expected_version),
        .i_full            (q_full),
        .o_push            (q_push),
        .o_cmd             (front_cmd)
    );

    mpe_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    mpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .i_min_length(r_min_length),
        .o_out       (o_out)
    );

endmodule

/* test/mpdu_packet_extractor_tb.sv */
// Self-checking bench for the M_PDU packet extractor: framed byte streams against a predictor.
`timescale 1ns / 1ps
module mpdu_packet_extractor_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;

    class packet_scoreboard;
        logic [mpe_pkg::CHAN_W-1:0] filler;
        logic [1:0]                 version;
        logic [mpe_pkg::LEN_W-1:0]  min_len;
        int unsigned                zone_pos;
        logic [mpe_pkg::PTR_W-1:0]  ptr;
        logic                       discard;
        logic                       synced [mpe_pkg::CHANNELS];
        logic [2:0]                 hdr_cnt [mpe_pkg::CHANNELS];
        logic [mpe_pkg::HDR_W-1:0]  hdr [mpe_pkg::CHANNELS];
        logic [mpe_pkg::REM_W-1:0]  remaining [mpe_pkg::CHANNELS];
        mpe_pkg::t_result           pending [$];
        int                         errors;

        function new();
            filler   = mpe_pkg::RST_FILLER_CHANNEL;
            version  = mpe_pkg::RST_EXPECTED_VERSION;
            min_len  = mpe_pkg::RST_MIN_LENGTH;
            zone_pos = 0;
            ptr      = '0;
            discard  = 1'b1;
            errors   = 0;
            for (int i = 0; i < mpe_pkg::CHANNELS; i++) begin
                synced[i]    = 1'b0;
                hdr_cnt[i]   = '0;
                hdr[i]       = '0;
                remaining[i] = '0;
            end
        endfunction

        function void write_reg(logic [mpe_pkg::CFG_IDX_W-1:0] idx,
                                logic [mpe_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                mpe_pkg::CFG_FILLER_CHANNEL:   filler = data[mpe_pkg::CHAN_W-1:0];
                mpe_pkg::CFG_EXPECTED_VERSION: version = data[1:0];
                mpe_pkg::CFG_MIN_LENGTH:       min_len = data[mpe_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the frame and channel state by one accepted beat.
        function void note_byte(logic start, logic [mpe_pkg::CHAN_W-1:0] ch, logic [1:0] ver,
                                logic [7:0] data);
            int unsigned      pos;
            logic [15:0]      w0;
            logic [15:0]      w1;
            logic [15:0]      len;
            mpe_pkg::t_result r;
            if (start) begin
                zone_pos = 0;
                discard  = (ch == filler) || (ver != version);
            end
            pos = zone_pos;
            if (zone_pos < mpe_pkg::POS_MAX)
                zone_pos++;
            if (discard)
                return;
            if (pos == 0) begin
                ptr = {data[2:0], 8'h00};
            end else if (pos == 1) begin
                ptr = {ptr[10:8], data};
                if (ptr >= mpe_pkg::ZONE_BYTES && ptr != mpe_pkg::NO_HEADER_PTR)
                    synced[ch] = 1'b0;
            end else if (pos < mpe_pkg::POS_MAX) begin
                if (ptr < mpe_pkg::ZONE_BYTES && (pos - 2) == ptr) begin
                    synced[ch]    = 1'b1;
                    hdr_cnt[ch]   = '0;
                    hdr[ch]       = '0;
                    remaining[ch] = '0;
                end
                if (synced[ch]) begin
                    if (hdr_cnt[ch] < mpe_pkg::HDR_BYTES) begin
                        hdr[ch] = {hdr[ch][mpe_pkg::HDR_W-9:0], data};
                        hdr_cnt[ch]++;
                        if (hdr_cnt[ch] == mpe_pkg::HDR_BYTES) begin
                            len = hdr[ch][15:0];
                            if (len < min_len)
                                synced[ch] = 1'b0;
                            else
                                remaining[ch] = {1'b0, len} + 17'd1;
                        end
                    end else begin
                        w0 = hdr[ch][47:32];
                        w1 = hdr[ch][31:16];
                        if (remaining[ch] != 0)
                            remaining[ch]--;
                        r.out_byte       = data;
                        r.out_channel    = ch;
                        r.app_id         = w0[10:0];
                        r.packet_version = w0[15:13];
                        r.packet_type    = w0[12];
                        r.has_secondary  = w0[11];
                        r.seq_flags      = w1[15:14];
                        r.seq_number     = w1[13:0];
                        r.last_byte      = (remaining[ch] == 0);
                        if (r.last_byte) begin
                            hdr_cnt[ch] = '0;
                            hdr[ch]     = '0;
                        end
                        pending = {pending, r};
                    end
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
                errors++;
            end
        endfunction

        function void check_beat(mpe_pkg::t_result got);
            mpe_pkg::t_result want;
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual byte %0d chan %0d",
                         $time, got.out_byte, got.out_channel);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("out_channel", want.out_channel, got.out_channel);
            compare_field("app_id", want.app_id, got.app_id);
            compare_field("packet_version", want.packet_version, got.packet_version);
            compare_field("packet_type", want.packet_type, got.packet_type);
            compare_field("has_secondary", want.has_secondary, got.has_secondary);
            compare_field("seq_flags", want.seq_flags, got.seq_flags);
            compare_field("seq_number", want.seq_number, got.seq_number);
            compare_field("last_byte", want.last_byte, got.last_byte);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mpe_in_if  in_ch();
    mpe_out_if out_ch();
    mpe_cfg_if cfg_ch();

    mpdu_packet_extractor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    packet_scoreboard sb;

    int cycles        = 0;
    int accepted      = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;

    logic [mpe_pkg::CHAN_W-1:0] cur_filler  = mpe_pkg::RST_FILLER_CHANNEL;
    logic [1:0]                 cur_version = mpe_pkg::RST_EXPECTED_VERSION;
    logic [mpe_pkg::LEN_W-1:0]  cur_min_len = mpe_pkg::RST_MIN_LENGTH;
    logic [mpe_pkg::CHAN_W-1:0] chan_pool [4];

    // Per-channel packet stream the well-formed frames are cut from.
    logic [mpe_pkg::HDR_W-1:0] gen_hdr [mpe_pkg::CHANNELS];
    int                        gen_idx [mpe_pkg::CHANNELS];
    int                        gen_total [mpe_pkg::CHANNELS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int               holds_served;
        int               hold_left;
        mpe_pkg::t_result beat;
        holds_served = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                beat = {out_ch.out_byte, out_ch.out_channel, out_ch.app_id,
                        out_ch.packet_version, out_ch.packet_type, out_ch.has_secondary,
                        out_ch.seq_flags, out_ch.seq_number, out_ch.last_byte};
                sb.check_beat(beat);
            end
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic start, input logic [mpe_pkg::CHAN_W-1:0] ch,
                             input logic [1:0] ver, input logic [7:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
            @(negedge i_clk);
        in_ch.valid         = 1'b1;
        in_ch.frame_start   = start;
        in_ch.channel       = ch;
        in_ch.frame_version = ver;
        in_ch.in_byte       = data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_byte(start, ch, ver, data);
        accepted++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [mpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mpe_pkg::CFG_DAT_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [mpe_pkg::CHAN_W-1:0] filler, input logic [1:0] ver,
                             input logic [mpe_pkg::LEN_W-1:0] min_len);
        wait_drained();
        write_reg(mpe_pkg::CFG_FILLER_CHANNEL,
                  {{(mpe_pkg::CFG_DAT_W-mpe_pkg::CHAN_W){1'b0}}, filler});
        write_reg(mpe_pkg::CFG_EXPECTED_VERSION, {{(mpe_pkg::CFG_DAT_W-2){1'b0}}, ver});
        write_reg(mpe_pkg::CFG_MIN_LENGTH, min_len);
        cur_filler  = filler;
        cur_version = ver;
        cur_min_len = min_len;
        for (int i = 0; i < 4; i++) begin
            chan_pool[i] = mpe_pkg::CHAN_W'($urandom_range(0, mpe_pkg::CHANNELS - 1));
            if (chan_pool[i] == filler)
                chan_pool[i] = ~filler;
        end
    endtask

    function automatic logic [7:0] stream_byte(input int ch);
        logic [15:0] len;
        logic [7:0]  data;
        if (gen_idx[ch] >= gen_total[ch]) begin
            if (cur_min_len != 0 && $urandom_range(0, 9) == 0)
                len = 16'($urandom_range(0, cur_min_len - 1));
            else if (cur_min_len > 16'hFFFF - 16'd24)
                len = 16'hFFFF;
            else
                len = cur_min_len + 16'($urandom_range(0, 24));
            gen_hdr[ch]   = {16'($urandom), 16'($urandom), len};
            gen_total[ch] = 7 + int'(len);
            gen_idx[ch]   = 0;
        end
        if (gen_idx[ch] < 6)
            data = 8'(gen_hdr[ch] >> (8 * (5 - gen_idx[ch])));
        else
            data = 8'($urandom);
        gen_idx[ch]++;
        return data;
    endfunction

    // A negative forced pointer lets the pointer follow the channel's packet stream.
    task automatic send_frame(input logic [mpe_pkg::CHAN_W-1:0] ch, input logic [1:0] ver,
                              input int zone_len, input int forced_ptr);
        int                        left;
        logic [mpe_pkg::PTR_W-1:0] fhp;
        left = gen_total[ch] - gen_idx[ch];
        if (forced_ptr >= 0)
            fhp = mpe_pkg::PTR_W'(forced_ptr);
        else if (left < zone_len)
            fhp = mpe_pkg::PTR_W'(left);
        else
            fhp = mpe_pkg::NO_HEADER_PTR;
        send_byte(1'b1, ch, ver, {5'($urandom), fhp[10:8]});
        send_byte(1'b0, ch, ver, fhp[7:0]);
        for (int i = 0; i < zone_len; i++)
            send_byte(1'b0, ch, ver, stream_byte(ch));
    endtask

    task automatic junk_frame(input logic [mpe_pkg::CHAN_W-1:0] ch, input logic [1:0] ver,
                              input int n);
        send_byte(1'b1, ch, ver, 8'($urandom));
        for (int i = 0; i < n; i++)
            send_byte(1'b0, ch, ver, 8'($urandom));
    endtask

    task automatic run_traffic(input int n_items);
        int                         stop_at;
        int                         pick;
        int                         zone_len;
        int                         bad_ptr;
        logic [mpe_pkg::CHAN_W-1:0] ch;
        stop_at = accepted + n_items;
        while (accepted < stop_at) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) != 0)
                ch = chan_pool[$urandom_range(0, 3)];
            else
                ch = mpe_pkg::CHAN_W'($urandom);
            if (ch == cur_filler)
                ch = chan_pool[0];
            if ($urandom_range(0, 7) == 0)
                zone_len = $urandom_range(0, 2);
            else
                zone_len = $urandom_range(3, 40);
            case ($urandom_range(0, 2))
                0:       bad_ptr = $urandom_range(0, 2047);
                1:       bad_ptr = $urandom_range(mpe_pkg::ZONE_BYTES - 2,
                                                  mpe_pkg::ZONE_BYTES + 2);
                default: bad_ptr = $urandom_range(0, zone_len);
            endcase
            if (pick < 68)
                send_frame(ch, cur_version, zone_len, -1);
            else if (pick < 76)
                send_frame(ch, cur_version, zone_len, bad_ptr);
            else if (pick < 82)
                junk_frame(cur_filler, 2'($urandom), zone_len);
            else if (pick < 88)
                junk_frame(ch, cur_version ^ 2'($urandom_range(1, 3)), zone_len);
            else
                for (int i = 0; i < zone_len; i++)
                    send_byte($urandom_range(0, 9) == 0, mpe_pkg::CHAN_W'($urandom),
                              2'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [7:0] first_pkt [14];
        first_pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h05,
                      8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h00, 8'h00};
        sb = new();
        in_ch.valid         = 1'b0;
        in_ch.frame_start   = 1'b0;
        in_ch.channel       = '0;
        in_ch.frame_version = '0;
        in_ch.in_byte       = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        for (int i = 0; i < mpe_pkg::CHANNELS; i++) begin
            gen_hdr[i]   = '0;
            gen_idx[i]   = 0;
            gen_total[i] = 0;
        end
        for (int i = 0; i < 4; i++)
            chan_pool[i] = mpe_pkg::CHAN_W'(i + 1);
        tx_idle_pct = 6;
        rx_idle_pct = 64;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: a stray beat, a full packet with spare pointer bits set,
        // filler and wrong-version frames, the no-header pointer and an invalid pointer.
        send_byte(1'b0, 6'd5, 2'd1, 8'hAA);
        send_byte(1'b1, 6'd3, 2'd1, 8'hF8);
        send_byte(1'b0, 6'd3, 2'd1, 8'h00);
        foreach (first_pkt[i])
            send_byte(1'b0, 6'd3, 2'd1, first_pkt[i]);
        send_byte(1'b1, 6'd63, 2'd1, 8'h00);
        send_byte(1'b0, 6'd63, 2'd1, 8'h00);
        send_byte(1'b1, 6'd3, 2'd0, 8'h07);
        send_byte(1'b1, 6'd3, 2'd1, 8'h07);
        send_byte(1'b0, 6'd3, 2'd1, 8'hFF);
        send_byte(1'b0, 6'd3, 2'd1, 8'h00);
        send_byte(1'b0, 6'd3, 2'd1, 8'h00);
        send_byte(1'b1, 6'd3, 2'd1, 8'h03);
        send_byte(1'b0, 6'd3, 2'd1, 8'h74);
        send_byte(1'b0, 6'd3, 2'd1, 8'h12);

        configure(6'd0, 2'd0, 16'd0);
        run_traffic(230);

        configure(6'd63, 2'd3, 16'hFFFF);
        tx_idle_pct = 64;
        rx_idle_pct = 6;
        run_traffic(115);
        wait_drained();
        run_traffic(115);

        configure(6'd22, 2'd2, 16'd12);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        run_traffic(150);
        run_traffic(150);

        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
